// File: sv/ddpd_pkg.sv
// Shared types and constants for the differential drive PD controller.
`timescale 1ns / 1ps

package ddpd_pkg;

	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 16;
	localparam int TARGET_W    = 16;
	localparam int WINDOW_W    = 15;
	localparam int DRIVE_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int OUT_TDATA_W = 2 * DRIVE_W;
	localparam int OUT_TUSER_W = 2;

	localparam logic [GAIN_W-1:0]   ANGLE_P_RST    = 16'd157;
	localparam logic [GAIN_W-1:0]   ANGLE_D_RST    = 16'd66;
	localparam logic [GAIN_W-1:0]   DISTANCE_P_RST = 16'd197;
	localparam logic [GAIN_W-1:0]   DISTANCE_D_RST = 16'd66;
	localparam logic [TARGET_W-1:0] TARGET_RST     = 16'd0;
	localparam logic [WINDOW_W-1:0] WINDOW_RST     = 15'd100;

	localparam int DRIVE_MAX = 32767;
	localparam int DRIVE_MIN = -32768;

	// Output flag positions in tuser
	localparam int OUT_IN_WINDOW_BIT = 0;
	localparam int OUT_GOAL_BIT      = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ANGLE_P_GAIN    = 3'd0,
		REG_ANGLE_D_GAIN    = 3'd1,
		REG_DISTANCE_P_GAIN = 3'd2,
		REG_DISTANCE_D_GAIN = 3'd3,
		REG_TARGET_DISTANCE = 3'd4,
		REG_TARGET_ANGLE    = 3'd5,
		REG_DISTANCE_WINDOW = 3'd6,
		REG_ANGLE_WINDOW    = 3'd7
	} cfg_reg_t;

endpackage

// File: sv/differential_drive_pd_controller_unit.sv
// Top level of the differential drive PD position controller.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one control tick per beat: tdata carries the left and
// right encoder counts, tuser carries the restart flag. Restart clears the
// stored errors and the done flag before the tick is evaluated.
// The master stream returns one beat per tick: tdata carries the saturated
// left and right drives (signed, DRIVE_FRAC_BITS fraction bits), tuser carries
// in_window and the sticky goal_reached flag.
// Gains, targets and windows are written through cfg_we / cfg_index / cfg_data
// while the stream is idle.
// The beat lands in the input register, then errors, the four gain products,
// the sums and the saturation are formed in one pass into the output register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the input and output registers hold and
// s_axis_tready drops; it stays high while the output register is empty or
// being taken.
// Reset loads the default gains and windows, zero targets, clears the stored
// errors, the done flag and both valid bits.
module differential_drive_pd_controller_unit
	import ddpd_pkg::*;
#(
	parameter int COUNT_WIDTH     = 16,
	parameter int DRIVE_FRAC_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// left_count, right_count, zero fill to whole bytes
	input  logic [((2*COUNT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// restart
	input  logic [0:0]               s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// left_drive, right_drive
	output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
	// in_window, goal_reached
	output logic [OUT_TUSER_W-1:0]   m_axis_tuser
);

	localparam int CW    = COUNT_WIDTH;
	localparam int AW    = (CW + 1 > TARGET_W) ? CW + 1 : TARGET_W;
	localparam int EW    = AW + 1;          // error width
	localparam int DW    = EW + 1;          // error change width
	localparam int PW    = DW + GAIN_W + 1; // product width
	localparam int TW    = PW + 2;          // drive sum width
	localparam int SHIFT = GAIN_FRAC - DRIVE_FRAC_BITS;

	// Configuration registers
	logic [GAIN_W-1:0]          angle_p_q, angle_d_q, dist_p_q, dist_d_q;
	logic signed [TARGET_W-1:0] target_dist_q, target_angle_q;
	logic [WINDOW_W-1:0]        dist_win_q, angle_win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_p_q      <= ANGLE_P_RST;
			angle_d_q      <= ANGLE_D_RST;
			dist_p_q       <= DISTANCE_P_RST;
			dist_d_q       <= DISTANCE_D_RST;
			target_dist_q  <= TARGET_RST;
			target_angle_q <= TARGET_RST;
			dist_win_q     <= WINDOW_RST;
			angle_win_q    <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANGLE_P_GAIN:    angle_p_q      <= cfg_data;
				REG_ANGLE_D_GAIN:    angle_d_q      <= cfg_data;
				REG_DISTANCE_P_GAIN: dist_p_q       <= cfg_data;
				REG_DISTANCE_D_GAIN: dist_d_q       <= cfg_data;
				REG_TARGET_DISTANCE: target_dist_q  <= cfg_data;
				REG_TARGET_ANGLE:    target_angle_q <= cfg_data;
				REG_DISTANCE_WINDOW: dist_win_q     <= cfg_data[WINDOW_W-1:0];
				REG_ANGLE_WINDOW:    angle_win_q    <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: both registers move whenever the output slot frees up
	logic adv;
	logic out_valid_q;
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: input register
	logic                 v_s1, restart_s1;
	logic signed [CW-1:0] left_s1, right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s1    <= s_axis_tdata[CW-1:0];
			right_s1   <= s_axis_tdata[2*CW-1:CW];
			restart_s1 <= s_axis_tuser[0];
		end
	end

	// Error forming
	logic signed [CW:0]   diff_rl, sum_lr, sum_adj;
	logic signed [CW-1:0] half_lr;
	logic signed [EW-1:0] ea, ed, prev_a_eff, prev_d_eff, awin, dwin;
	logic signed [DW-1:0] da, dd;
	logic                 in_win, done_next;
	logic signed [EW-1:0] prev_a_q, prev_d_q;
	logic                 done_q;

	assign diff_rl = (CW+1)'(right_s1) - (CW+1)'(left_s1);
	assign sum_lr  = (CW+1)'(right_s1) + (CW+1)'(left_s1);
	// bias negative sums by one so the halving truncates toward zero
	assign sum_adj = sum_lr + {{CW{1'b0}}, sum_lr[CW]};
	assign half_lr = sum_adj[CW:1];

	assign ea = EW'(target_angle_q) - EW'(diff_rl);
	assign ed = EW'(target_dist_q) - EW'(half_lr);

	assign prev_a_eff = restart_s1 ? '0 : prev_a_q;
	assign prev_d_eff = restart_s1 ? '0 : prev_d_q;
	assign da = DW'(ea) - DW'(prev_a_eff);
	assign dd = DW'(ed) - DW'(prev_d_eff);

	assign awin   = $signed({{(EW-WINDOW_W){1'b0}}, angle_win_q});
	assign dwin   = $signed({{(EW-WINDOW_W){1'b0}}, dist_win_q});
	assign in_win = (-awin < ea) && (ea < awin) && (-dwin < ed) && (ed < dwin);
	assign done_next = (done_q && !restart_s1) || in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_d_q <= '0;
			done_q   <= 1'b0;
		end else if (adv && v_s1) begin
			prev_a_q <= ea;
			prev_d_q <= ed;
			done_q   <= done_next;
		end
	end

	// Gain products
	logic signed [PW-1:0] pa, pda, pd, pdd;

	assign pa  = PW'(ea) * PW'($signed({1'b0, angle_p_q}));
	assign pda = PW'(da) * PW'($signed({1'b0, angle_d_q}));
	assign pd  = PW'(ed) * PW'($signed({1'b0, dist_p_q}));
	assign pdd = PW'(dd) * PW'($signed({1'b0, dist_d_q}));

	// Sum, floor shift and saturation
	function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] s;
		s = v >>> SHIFT;
		if (s > TW'(DRIVE_MAX))
			return DRIVE_W'(DRIVE_MAX);
		else if (s < TW'(DRIVE_MIN))
			return DRIVE_W'(DRIVE_MIN);
		else
			return s[DRIVE_W-1:0];
	endfunction

	logic signed [TW-1:0] a_term, d_term, left_sum, right_sum;
	assign a_term    = TW'(pa) + TW'(pda);
	assign d_term    = TW'(pd) + TW'(pdd);
	assign left_sum  = d_term - a_term;
	assign right_sum = d_term + a_term;

	// Output register
	logic [DRIVE_W-1:0] left_drive_q, right_drive_q;
	logic               in_window_q, goal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_drive_q  <= sat_drive(left_sum);
			right_drive_q <= sat_drive(right_sum);
			in_window_q   <= in_win;
			goal_q        <= done_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {right_drive_q, left_drive_q};
	always_comb begin
		m_axis_tuser                    = '0;
		m_axis_tuser[OUT_IN_WINDOW_BIT] = in_window_q;
		m_axis_tuser[OUT_GOAL_BIT]      = goal_q;
	end

	// A tick inside the windows always carries the done flag
	a_window_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[OUT_IN_WINDOW_BIT] |-> m_axis_tuser[OUT_GOAL_BIT])
		else $error("in_window without goal_reached");

	// An accepted beat lands in the input stage
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted beat lost at input stage");

	// Stored errors move only when a real tick advances
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && v_s1) |=> $stable(prev_a_q) && $stable(prev_d_q) && $stable(done_q))
		else $error("stored error changed without a tick");

	// A stalled output holds both registers
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(v_s1) && $stable(out_valid_q))
		else $error("pipeline moved during stall");

	// A restart tick with no window hit clears done
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 && restart_s1 && !in_win |=> !done_q)
		else $error("restart did not clear done");

endmodule

// File: verif/differential_drive_pd_controller_unit_tb.sv
// Self-checking testbench for the differential drive PD controller with a shadow predictor.
`timescale 1ns / 1ps

module differential_drive_pd_controller_unit_tb;
	import ddpd_pkg::*;

	localparam int COUNT_W    = 16;
	localparam int DRIVE_FRAC = 12;
	localparam int FRAC_SHIFT = GAIN_FRAC - DRIVE_FRAC;

	typedef struct {
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
		logic                      restart;
	} tick_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
		logic                      in_window;
		logic                      goal_reached;
	} drive_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [2*COUNT_W-1:0]   s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	differential_drive_pd_controller_unit #(
		.COUNT_WIDTH    (COUNT_W),
		.DRIVE_FRAC_BITS(DRIVE_FRAC)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Shadow copy of the controller registers and state
	longint angle_kp = ANGLE_P_RST;
	longint angle_kd = ANGLE_D_RST;
	longint dist_kp = DISTANCE_P_RST;
	longint dist_kd = DISTANCE_D_RST;
	longint goal_dist = 0;
	longint goal_angle = 0;
	longint dist_win = WINDOW_RST;
	longint angle_win = WINDOW_RST;
	longint last_angle_err = 0;
	longint last_dist_err = 0;
	bit     done_latched = 1'b0;

	tick_t         tick_backlog[$];
	drive_result_t pending_drives[$];
	int            ticks_issued = 0;
	int            ticks_answered = 0;
	int            mismatches = 0;
	bit            in_fire = 1'b0;
	bit            calm = 1'b0;

	function automatic logic signed [DRIVE_W-1:0] clamp_drive(longint q16);
		longint v;
		v = q16 >>> FRAC_SHIFT;
		if (v > DRIVE_MAX)
			v = DRIVE_MAX;
		if (v < DRIVE_MIN)
			v = DRIVE_MIN;
		return DRIVE_W'(v);
	endfunction

	function automatic drive_result_t control_tick(tick_t t);
		drive_result_t r;
		longint lc, rc, ea, ed, a_term, d_term;
		bit in_win;
		if (t.restart) begin
			last_angle_err = 0;
			last_dist_err = 0;
			done_latched = 1'b0;
		end
		lc = t.left_count;
		rc = t.right_count;
		ea = goal_angle - (rc - lc);
		// longint division truncates toward zero
		ed = goal_dist - (rc + lc) / 2;
		a_term = angle_kp * ea + angle_kd * (ea - last_angle_err);
		d_term = dist_kp * ed + dist_kd * (ed - last_dist_err);
		last_angle_err = ea;
		last_dist_err = ed;
		in_win = (-angle_win < ea) && (ea < angle_win)
			&& (-dist_win < ed) && (ed < dist_win);
		if (in_win)
			done_latched = 1'b1;
		r.left_drive = clamp_drive(d_term - a_term);
		r.right_drive = clamp_drive(d_term + a_term);
		r.in_window = in_win;
		r.goal_reached = done_latched;
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor: track register writes, score results, predict accepted ticks
	always @(posedge clk) begin : monitor
		drive_result_t want;
		tick_t seen;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANGLE_P_GAIN:    angle_kp = cfg_data;
				REG_ANGLE_D_GAIN:    angle_kd = cfg_data;
				REG_DISTANCE_P_GAIN: dist_kp = cfg_data;
				REG_DISTANCE_D_GAIN: dist_kd = cfg_data;
				REG_TARGET_DISTANCE: goal_dist = $signed(cfg_data);
				REG_TARGET_ANGLE:    goal_angle = $signed(cfg_data);
				REG_DISTANCE_WINDOW: dist_win = cfg_data[WINDOW_W-1:0];
				REG_ANGLE_WINDOW:    angle_win = cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_drives.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual data %h user %b",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_drives.pop_front();
				check_field("left_drive", want.left_drive,
					$signed(m_axis_tdata[DRIVE_W-1:0]));
				check_field("right_drive", want.right_drive,
					$signed(m_axis_tdata[2*DRIVE_W-1:DRIVE_W]));
				check_field("in_window", want.in_window, m_axis_tuser[OUT_IN_WINDOW_BIT]);
				check_field("goal_reached", want.goal_reached, m_axis_tuser[OUT_GOAL_BIT]);
				ticks_answered++;
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			seen.left_count = s_axis_tdata[COUNT_W-1:0];
			seen.right_count = s_axis_tdata[2*COUNT_W-1:COUNT_W];
			seen.restart = s_axis_tuser[0];
			pending_drives.push_back(control_tick(seen));
		end
	end

	// Driver: present ticks from the backlog, idle and stall at random
	always @(negedge clk) begin : driver
		tick_t t;
		m_axis_tready <= calm || ($urandom_range(99) >= 34);
		if (!s_axis_tvalid || in_fire) begin
			if (tick_backlog.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
				t = tick_backlog.pop_front();
				s_axis_tdata <= {t.right_count, t.left_count};
				s_axis_tuser <= t.restart;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	task automatic issue(int left, int right, bit restart);
		tick_t t;
		t.left_count = COUNT_W'(left);
		t.right_count = COUNT_W'(right);
		t.restart = restart;
		tick_backlog.push_back(t);
		ticks_issued++;
	endtask

	task automatic drain();
		while (ticks_answered != ticks_issued)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic program_all(logic [15:0] akp, logic [15:0] akd, logic [15:0] dkp,
			logic [15:0] dkd, logic [15:0] tdist, logic [15:0] tang,
			logic [15:0] dwin, logic [15:0] awin);
		write_reg(REG_ANGLE_P_GAIN, akp);
		write_reg(REG_ANGLE_D_GAIN, akd);
		write_reg(REG_DISTANCE_P_GAIN, dkp);
		write_reg(REG_DISTANCE_D_GAIN, dkd);
		write_reg(REG_TARGET_DISTANCE, tdist);
		write_reg(REG_TARGET_ANGLE, tang);
		write_reg(REG_DISTANCE_WINDOW, dwin);
		write_reg(REG_ANGLE_WINDOW, awin);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_target();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'($signed($urandom_range(4000)) - 2000);
	endfunction

	function automatic logic [15:0] pick_window();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'($urandom_range(3000, 1));
		endcase
	endfunction

	// Mostly trajectories that settle around the goal, with wild counts mixed in
	task automatic queue_trajectory(int n, int tdist, int tang);
		int base_l, spread, noise_l, noise_r;
		spread = 400;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 30) begin
				issue($urandom, $urandom, $urandom_range(99) < 5);
			end else begin
				if ($urandom_range(99) < 10)
					spread = $urandom_range(600);
				else if (spread > 0)
					spread = spread * 3 / 4;
				base_l = tdist - tang / 2;
				noise_l = $signed($urandom_range(2 * spread)) - spread;
				noise_r = $signed($urandom_range(2 * spread)) - spread;
				issue(base_l + noise_l, base_l + tang + noise_r, $urandom_range(99) < 4);
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] tdist, tang;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: window edges, truncation of the count average, restart
		issue(0, 0, 1'b1);
		issue(0, 0, 1'b0);
		issue(32767, 32767, 1'b0);
		issue(-32768, -32768, 1'b0);
		issue(-32768, 32767, 1'b0);
		issue(32767, -32768, 1'b0);
		issue(-1, -2, 1'b0);
		issue(1, 2, 1'b0);
		issue(99, 99, 1'b0);
		issue(100, 100, 1'b0);
		issue(0, 100, 1'b0);
		issue(32767, 0, 1'b1);
		issue(-50, 49, 1'b0);
		drain();

		// Full gains, extreme targets, zero windows: saturation both ways
		program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'd0, 16'd0);
		issue(-32768, -32768, 1'b1);
		issue(32767, 32767, 1'b0);
		issue(-32768, 32767, 1'b0);
		issue(32767, -32768, 1'b0);
		issue(16383, -16384, 1'b0);
		drain();

		// Zero gains, opposite targets, widest windows
		program_all(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
		issue(-32768, 0, 1'b0);
		issue(-16384, 16383, 1'b0);
		issue(0, 0, 1'b0);
		issue(-32768, -32768, 1'b1);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			tdist = pick_target();
			tang = pick_target();
			program_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), tdist, tang,
				pick_window(), pick_window());
			calm <= (ph == 4);
			queue_trajectory(135, $signed(tdist), $signed(tang));
			drain();
			calm <= 1'b0;
		end

		repeat (12) @(posedge clk);
		if (mismatches == 0 && pending_drives.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: differential_drive_pd_controller_unit.f
sv/ddpd_pkg.sv
sv/differential_drive_pd_controller_unit.sv
verif/differential_drive_pd_controller_unit_tb.sv
